@@ hdl/shared_region_access_decoder_unit_defines.svh @@
// Assertion macros shared by the decoder's checker.
`ifndef SHARED_REGION_ACCESS_DECODER_UNIT_DEFINES_SVH
`define SHARED_REGION_ACCESS_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRAD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRAD_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/srad_pkg.sv @@
// Types and constants for the shared region access decoder.
`default_nettype none

package srad_pkg;

  localparam int unsigned IN_TDATA_W  = 224;
  localparam int unsigned OUT_TDATA_W = 208;
  localparam int unsigned OUT_TUSER_W = 3;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_STORE = 2'd1,
    KIND_OTHER = 2'd2
  } srad_kind_e;

  // configuration register indexes
  localparam logic CFG_WIN_START = 1'b0;
  localparam logic CFG_WIN_END   = 1'b1;

  // instruction length field, insn[1:0]
  localparam logic [1:0] QUAD_C0   = 2'b00;
  localparam logic [1:0] QUAD_FULL = 2'b11;

  // major opcodes, insn[6:2]
  localparam logic [4:0] OP_LOAD     = 5'h00;
  localparam logic [4:0] OP_LOAD_FP  = 5'h01;
  localparam logic [4:0] OP_STORE    = 5'h08;
  localparam logic [4:0] OP_STORE_FP = 5'h09;

  // compressed quadrant-0 width select, insn[14:13]
  localparam logic [1:0] CSEL_RSVD = 2'd0;
  localparam logic [1:0] CSEL_FP   = 2'd1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] fault_addr;
    logic [63:0] pc;
    logic [31:0] insn_word;
    logic [63:0] read_data;
  } srad_req_t;

  typedef struct packed {
    logic        fatal;
    logic        is_store;
    logic        is_float;
    logic [4:0]  reg_index;
    logic [3:0]  access_bytes;
    logic [63:0] window_offset;
    logic [63:0] load_value;
    logic        write_int_reg;
    logic [63:0] next_pc;
  } srad_result_t;

endpackage

`default_nettype wire

@@ hdl/srad_in_stage.sv @@
// Input register stage: takes a request off the slave stream and holds it for decode.
`default_nettype none

module srad_in_stage
  import srad_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_valid_i,
  output logic                       s_ready_o,
  input  wire logic [1:0]            s_kind_i,
  input  wire logic [IN_TDATA_W-1:0] s_data_i,
  input  wire logic                  down_ready_i,
  output logic                       req_valid_o,
  output srad_req_t                  req_o
);

  logic      valid_q, valid_d;
  srad_req_t req_q;
  logic      take;

  // Empty, or the held request moves on this cycle.
  assign s_ready_o = !valid_q || down_ready_i;
  assign take      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (down_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q.kind       <= s_kind_i;
      req_q.fault_addr <= s_data_i[63:0];
      req_q.pc         <= s_data_i[127:64];
      req_q.insn_word  <= s_data_i[159:128];
      req_q.read_data  <= s_data_i[223:160];
    end
  end

  assign req_valid_o = valid_q;
  assign req_o       = req_q;

endmodule

`default_nettype wire

@@ hdl/srad_decode.sv @@
// Single-pass decode of one faulting access into a handled or fatal result.
`default_nettype none

module srad_decode
  import srad_pkg::*;
(
  input  wire srad_req_t     req_i,
  input  wire logic [63:0]   win_start_i,
  input  wire logic [63:0]   win_end_i,
  output srad_result_t       res_o
);

  logic        is_ld, is_st, in_win;
  logic        ok, fp, unsig, compressed, sx, fatal;
  logic [4:0]  reg_idx;
  logic [3:0]  nbytes;
  logic [2:0]  f3;
  logic [4:0]  op;
  logic [1:0]  sel;
  logic [63:0] rd, ext;

  assign is_ld  = req_i.kind == KIND_LOAD;
  assign is_st  = req_i.kind == KIND_STORE;
  assign in_win = (req_i.fault_addr >= win_start_i) && (req_i.fault_addr < win_end_i);
  assign f3     = req_i.insn_word[14:12];
  assign op     = req_i.insn_word[6:2];
  assign sel    = req_i.insn_word[14:13];
  assign rd     = req_i.read_data;

  always_comb begin
    ok         = 1'b1;
    fp         = 1'b0;
    unsig      = 1'b0;
    compressed = 1'b0;
    reg_idx    = 5'd0;
    nbytes     = 4'd0;
    case (req_i.insn_word[1:0])
      QUAD_FULL: begin
        nbytes = 4'd1 << f3[1:0];
        unsig  = f3[2];
        case (op)
          OP_LOAD, OP_LOAD_FP: begin
            fp      = (op == OP_LOAD_FP);
            ok      = is_ld;
            reg_idx = req_i.insn_word[11:7];
          end
          OP_STORE, OP_STORE_FP: begin
            fp      = (op == OP_STORE_FP);
            ok      = is_st;
            reg_idx = req_i.insn_word[24:20];
          end
          default: ok = 1'b0;
        endcase
      end
      QUAD_C0: begin
        compressed = 1'b1;
        reg_idx    = {2'b01, req_i.insn_word[4:2]};
        // insn[15] set means store; it must oppose a load fault
        if ((req_i.insn_word[15] == is_ld) || (sel == CSEL_RSVD)) begin
          ok = 1'b0;
        end else if (sel == CSEL_FP) begin
          nbytes = 4'd8;
          fp     = 1'b1;
        end else begin
          nbytes = 4'd1 << sel;
        end
      end
      default: ok = 1'b0;
    endcase
  end

  assign sx = !fp && !unsig;

  always_comb begin
    case (nbytes)
      4'd1:    ext = {{56{sx & rd[7]}},  rd[7:0]};
      4'd2:    ext = {{48{sx & rd[15]}}, rd[15:0]};
      4'd4:    ext = {{32{sx & rd[31]}}, rd[31:0]};
      default: ext = rd;
    endcase
  end

  assign fatal = !(is_ld || is_st) || !in_win || !ok;

  always_comb begin
    res_o = '0;
    if (fatal) begin
      res_o.fatal = 1'b1;
    end else begin
      res_o.is_store      = is_st;
      res_o.is_float      = fp;
      res_o.reg_index     = reg_idx;
      res_o.access_bytes  = nbytes;
      res_o.window_offset = req_i.fault_addr - win_start_i;
      res_o.load_value    = is_ld ? ext : 64'd0;
      res_o.write_int_reg = is_ld && !fp && (reg_idx != 5'd0);
      res_o.next_pc       = req_i.pc + (compressed ? 64'd2 : 64'd4);
    end
  end

endmodule

`default_nettype wire

@@ hdl/srad_out_stage.sv @@
// Result register stage: holds a decoded result on the master stream until taken.
`default_nettype none

module srad_out_stage
  import srad_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   res_valid_i,
  input  wire srad_result_t           res_i,
  output logic                        up_ready_o,
  output logic                        m_valid_o,
  input  wire logic                   m_ready_i,
  output logic [OUT_TDATA_W-1:0]      m_data_o,
  output logic [OUT_TUSER_W-1:0]      m_user_o
);

  logic         valid_q, valid_d;
  srad_result_t res_q;
  logic         load;

  assign up_ready_o = !valid_q || m_ready_i;
  assign load       = res_valid_i && up_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
    end
  end

  assign m_valid_o = valid_q;
  assign m_user_o  = {res_q.is_float, res_q.is_store, res_q.fatal};
  assign m_data_o  = {6'd0, res_q.next_pc, res_q.write_int_reg, res_q.load_value,
                      res_q.window_offset, res_q.access_bytes, res_q.reg_index};

endmodule

`default_nettype wire

@@ hdl/shared_region_access_decoder_unit.sv @@
// Shared region access decoder: two-stage streaming decode of faulting loads and stores.
//
// Usage: one request per faulting access enters on the s_axis channel (kind in tuser,
// address, pc, instruction and read data in tdata). One result leaves on m_axis for
// every request, in order: fatal/is_store/is_float in tuser, the rest in tdata.
// The user must write the window bounds through the cfg write port only while the
// block is idle; the block itself does not enforce this. An accepted request is
// registered in the input register, decoded, and then registered in the result
// register, which drives m_axis_tvalid. One request is taken per cycle while
// m_axis_tready is high; the decode is a single combinational pass between the two
// registers, bounded by the 64-bit window compares, offset subtract and pc add.
// Reset clears both stage valids and the window to zero (every access fatal).
// When the receiver stalls, the result register holds and the input register
// still takes one more request; after that s_axis_tready drops until m_axis_tready
// frees the result register.
`default_nettype none

module shared_region_access_decoder_unit
  import srad_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration write port
  input  wire logic                   cfg_we_i,
  input  wire logic                   cfg_idx_i,
  input  wire logic [63:0]            cfg_data_i,
  // request stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // fields from bit 0: fault_addr[63:0], pc[127:64], insn_word[159:128],
  // read_data[223:160]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // fields from bit 0: kind[1:0]
  input  wire logic [1:0]             s_axis_tuser,
  // result stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // fields from bit 0: reg_index[4:0], access_bytes[8:5], window_offset[72:9],
  // load_value[136:73], write_int_reg[137], next_pc[201:138], zero pad[207:202]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  // fields from bit 0: fatal[0], is_store[1], is_float[2]
  output logic [OUT_TUSER_W-1:0]      m_axis_tuser
);

  logic [63:0]  win_start_q, win_end_q;
  logic         req_valid, dec_ready;
  srad_req_t    req;
  srad_result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= 64'd0;
      win_end_q   <= 64'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WIN_START: win_start_q <= cfg_data_i;
        CFG_WIN_END:   win_end_q   <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  srad_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_kind_i     (s_axis_tuser),
    .s_data_i     (s_axis_tdata),
    .down_ready_i (dec_ready),
    .req_valid_o  (req_valid),
    .req_o        (req)
  );

  srad_decode u_dec (
    .req_i       (req),
    .win_start_i (win_start_q),
    .win_end_i   (win_end_q),
    .res_o       (res)
  );

  srad_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (req_valid),
    .res_i       (res),
    .up_ready_o  (dec_ready),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_user_o    (m_axis_tuser)
  );

endmodule

`default_nettype wire

@@ hdl/srad_checker.sv @@
// Port-level assertions for the shared region access decoder, bound to the top level.
`default_nettype none
`include "shared_region_access_decoder_unit_defines.svh"

module srad_checker
  import srad_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic [OUT_TUSER_W-1:0] m_axis_tuser
);

  `SRAD_ASSERT_NXT(a_hold_on_stall, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  `SRAD_ASSERT_IMP(a_fatal_clean, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata == '0) && (m_axis_tuser[2:1] == 2'b00), "fatal result carries nonzero fields")

  `SRAD_ASSERT_IMP(a_width_legal, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0], (m_axis_tdata[8:5] == 4'd1) || (m_axis_tdata[8:5] == 4'd2) || (m_axis_tdata[8:5] == 4'd4) || (m_axis_tdata[8:5] == 4'd8), "handled access with illegal width")

  `SRAD_ASSERT_IMP(a_store_no_wb, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0] && m_axis_tuser[1], m_axis_tdata[137:73] == '0, "store result with load value or writeback")

endmodule

bind shared_region_access_decoder_unit srad_checker u_srad_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
